// ===== rtl/vti_pkg.sv =====
// Shared types and constants for the VLAN tag inserter.
`timescale 1ns / 1ps

package vti_pkg;

    localparam int unsigned AddrBytes    = 12;
    localparam int unsigned TagBytes     = 4;
    localparam int unsigned IdxW         = 4;
    localparam int unsigned TagCntW      = 3;
    localparam int unsigned CfgAddrW     = 3;
    localparam int unsigned CfgDataW     = 16;
    localparam int unsigned VidW         = 12;
    localparam logic [15:0] Ethertype8021q = 16'h8100;

    // byte_index value of the last address byte
    localparam logic [IdxW-1:0] LastAddrIdx = IdxW'(AddrBytes - 1);
    // saturation value of byte_index
    localparam logic [IdxW-1:0] SatIdx      = IdxW'(AddrBytes);
    localparam logic [TagCntW-1:0] TagCntFull = TagCntW'(TagBytes);

    typedef enum logic [CfgAddrW-1:0] {
        CFG_TAG_CONTROL   = 3'd0,
        CFG_USE_FRAME_TAG = 3'd1,
        CFG_NATIVE_EN     = 3'd2,
        CFG_NATIVE_VID    = 3'd3,
        CFG_TAG_PROTOCOL  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]     tag_control_word;
        logic            use_frame_tag;
        logic            native_match_enable;
        logic [VidW-1:0] native_vlan_id;
        logic [15:0]     tag_protocol_id;
    } t_cfg;

endpackage

// ===== rtl/vti_cfg_regs.sv =====
// Configuration register file of the VLAN tag inserter.
`timescale 1ns / 1ps

module vti_cfg_regs
    import vti_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TAG_CONTROL:   n_cfg.tag_control_word    = i_cfg_wdata;
                CFG_USE_FRAME_TAG: n_cfg.use_frame_tag       = i_cfg_wdata[0];
                CFG_NATIVE_EN:     n_cfg.native_match_enable = i_cfg_wdata[0];
                CFG_NATIVE_VID:    n_cfg.native_vlan_id      = i_cfg_wdata[VidW-1:0];
                CFG_TAG_PROTOCOL:  n_cfg.tag_protocol_id     = i_cfg_wdata;
                default:           n_cfg = r_cfg;   // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tag_control_word    <= '0;
            r_cfg.use_frame_tag       <= 1'b0;
            r_cfg.native_match_enable <= 1'b1;
            r_cfg.native_vlan_id      <= '0;
            r_cfg.tag_protocol_id     <= Ethertype8021q;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/vlan_tag_inserter.sv =====
// Top level: 802.1Q tag insertion on a byte stream.
`timescale 1ns / 1ps
//
//  channel | ports              | payload
//  --------+--------------------+------------------------------------------
//  in      | i_s_t*, o_s_tready | tdata: in_byte; tlast: in_last;
//          |                    | tuser: frame_tag
//  out     | o_m_t*, i_m_tready | tdata: out_byte; tlast: out_last
//  config  | i_cfg_*            | index 0..4, 16-bit write data
//
//  One byte per cycle in and out while nothing holds the flow; each byte passes
//  through one output register. After the twelfth byte of a tagged frame the
//  input holds while the four tag bytes leave from the same output register
//  (tag byte counter). Synchronous active-low reset clears frame state and
//  output valid. A stalled output holds its byte; input is taken in the same
//  cycle that register frees, unless tag bytes are still owed.

module vlan_tag_inserter
    import vti_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,   // [7:0] in_byte
    input  logic                i_s_tlast,
    input  logic [15:0]         i_s_tuser,   // [15:0] frame_tag
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [7:0]          o_m_tdata,   // [7:0] out_byte
    output logic                o_m_tlast,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata
);

    t_cfg cfg;

    vti_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    logic [IdxW-1:0]    r_byte_index, n_byte_index;
    logic [15:0]        r_latched_ctl, n_latched_ctl;
    logic               r_insert, n_insert;
    logic [TagCntW-1:0] r_tag_cnt, n_tag_cnt;
    logic               r_pend_last, n_pend_last;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;

    logic        out_free;
    logic        s_xfer;
    logic [15:0] ctl_now;
    logic        ins_now;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_tag_cnt == '0) && out_free;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    // control word and tag decision are taken on the first byte of a frame
    always_comb begin
        if (r_byte_index == '0) begin
            ctl_now = cfg.use_frame_tag ? i_s_tuser : cfg.tag_control_word;
            ins_now = !(cfg.native_match_enable &&
                        (ctl_now[VidW-1:0] == cfg.native_vlan_id));
        end else begin
            ctl_now = r_latched_ctl;
            ins_now = r_insert;
        end
    end

    always_comb begin
        n_byte_index  = r_byte_index;
        n_latched_ctl = r_latched_ctl;
        n_insert      = r_insert;
        n_tag_cnt     = r_tag_cnt;
        n_pend_last   = r_pend_last;
        n_out_valid   = r_out_valid;
        n_out_byte    = r_out_byte;
        n_out_last    = r_out_last;

        if (out_free) begin
            n_out_valid = 1'b0;
        end

        if (out_free && (r_tag_cnt != '0)) begin
            n_out_valid = 1'b1;
            n_tag_cnt   = r_tag_cnt - 1'b1;
            n_out_last  = 1'b0;
            case (r_tag_cnt)
                3'd4:    n_out_byte = cfg.tag_protocol_id[15:8];
                3'd3:    n_out_byte = cfg.tag_protocol_id[7:0];
                3'd2:    n_out_byte = r_latched_ctl[15:8];
                default: begin
                    n_out_byte = r_latched_ctl[7:0];
                    n_out_last = r_pend_last;
                end
            endcase
        end else if (s_xfer) begin
            n_out_valid   = 1'b1;
            n_out_byte    = i_s_tdata;
            n_latched_ctl = ctl_now;
            n_insert      = ins_now;
            if (ins_now && (r_byte_index == LastAddrIdx)) begin
                n_out_last  = 1'b0;
                n_tag_cnt   = TagCntFull;
                n_pend_last = i_s_tlast;
            end else begin
                n_out_last = i_s_tlast;
            end
            if (i_s_tlast) begin
                n_byte_index = '0;
                n_insert     = 1'b0;
            end else if (r_byte_index < SatIdx) begin
                n_byte_index = r_byte_index + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index  <= '0;
            r_latched_ctl <= '0;
            r_insert      <= 1'b0;
            r_tag_cnt     <= '0;
            r_pend_last   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_byte_index  <= n_byte_index;
            r_latched_ctl <= n_latched_ctl;
            r_insert      <= n_insert;
            r_tag_cnt     <= n_tag_cnt;
            r_pend_last   <= n_pend_last;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    // a frame end never leaves while tag bytes are still owed
    a_last_after_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_tag_cnt == '0))
        else $error("frame end emitted with tag bytes pending");

    a_idx_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= SatIdx)
        else $error("byte index past saturation");

    a_tag_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag_cnt <= TagCntFull)
        else $error("tag counter out of range");

    // tag bytes only follow the last address byte
    a_tag_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag_cnt != '0) |-> ((r_byte_index == SatIdx) || (r_byte_index == '0)))
        else $error("tag insertion outside header position");

    a_tag_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && ins_now && (r_byte_index == LastAddrIdx)) |=>
        (r_tag_cnt == TagCntFull) && r_out_valid && !r_out_last)
        else $error("tag sequence did not start after address bytes");

endmodule

// ===== tb/vlan_tag_inserter_tb.sv =====
// Self-checking testbench for the 802.1Q tag inserter: frames in, predicted byte stream out.
`timescale 1ns / 1ps

module vlan_tag_inserter_tb;
    import vti_pkg::*;

    localparam int CycleLimit   = 300000;
    localparam int SettleCycles = 8;
    localparam int LongStall    = 120;
    localparam int RandPhases   = 8;
    localparam int PhaseBytes   = 22;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] tag;
    } t_frame_byte;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata = '0;   // [7:0] in_byte
    logic                i_s_tlast = 1'b0;
    logic [15:0]         i_s_tuser = '0;   // [15:0] frame_tag
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [7:0]          o_m_tdata;        // [7:0] out_byte
    logic                o_m_tlast;
    logic                i_cfg_we = 1'b0;
    logic [CfgAddrW-1:0] i_cfg_addr = '0;
    logic [CfgDataW-1:0] i_cfg_wdata = '0;

    vlan_tag_inserter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    t_frame_byte in_bytes_q[$];
    t_out_beat   out_beats_q[$];
    t_out_beat   want_beat;
    int          err_cnt = 0;
    int          cyc_cnt = 0;
    bit          idle_en = 1'b1;
    bit          long_hold_req = 1'b0;
    int          src_gap = 0;
    int          snk_hold = 0;

    // shadow of the register file and frame state
    t_cfg            regs_m = '{tag_control_word: 16'h0, use_frame_tag: 1'b0,
                                native_match_enable: 1'b1, native_vlan_id: '0,
                                tag_protocol_id: Ethertype8021q};
    logic [IdxW-1:0] pos_cnt = '0;
    logic [15:0]     frame_ctl = '0;
    logic            frame_tagged = 1'b0;

    function automatic void push_beat(logic [7:0] d, logic l);
        t_out_beat b;
        b.data = d;
        b.last = l;
        out_beats_q = {out_beats_q, b};
    endfunction

    // expected output bytes for one accepted input byte
    function automatic void tag_insert_predict(logic [7:0] b, logic l, logic [15:0] ftag);
        if (pos_cnt == '0) begin
            frame_ctl = regs_m.use_frame_tag ? ftag : regs_m.tag_control_word;
            frame_tagged = !(regs_m.native_match_enable &&
                             frame_ctl[VidW-1:0] == regs_m.native_vlan_id);
        end
        if (frame_tagged && pos_cnt == LastAddrIdx) begin
            push_beat(b, 1'b0);
            push_beat(regs_m.tag_protocol_id[15:8], 1'b0);
            push_beat(regs_m.tag_protocol_id[7:0], 1'b0);
            push_beat(frame_ctl[15:8], 1'b0);
            push_beat(frame_ctl[7:0], l);
        end else begin
            push_beat(b, l);
        end
        if (l) begin
            pos_cnt = '0;
            frame_tagged = 1'b0;
        end else if (pos_cnt < SatIdx) begin
            pos_cnt = pos_cnt + 1'b1;
        end
    endfunction

    // input side
    always @(posedge i_clk) begin
        t_frame_byte nb;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                tag_insert_predict(i_s_tdata, i_s_tlast, i_s_tuser);
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap = src_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (idle_en && in_bytes_q.size() > 0 &&
                             $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(1, 18) - 1;
                    i_s_tvalid <= 1'b0;
                end else if (in_bytes_q.size() > 0) begin
                    nb = in_bytes_q.pop_front();
                    i_s_tdata  <= nb.data;
                    i_s_tlast  <= nb.last;
                    i_s_tuser  <= nb.tag;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: checker and ready pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (out_beats_q.size() == 0) begin
                    $error("unexpected output transfer: out_byte %h out_last %b",
                           o_m_tdata, o_m_tlast);
                    err_cnt++;
                end else begin
                    want_beat = out_beats_q.pop_front();
                    if (o_m_tdata !== want_beat.data) begin
                        $error("out_byte: expected %h, got %h", want_beat.data, o_m_tdata);
                        err_cnt++;
                    end
                    if (o_m_tlast !== want_beat.last) begin
                        $error("out_last: expected %b, got %b", want_beat.last, o_m_tlast);
                        err_cnt++;
                    end
                end
            end
            if (snk_hold > 0) begin
                snk_hold = snk_hold - 1;
                i_m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                snk_hold = LongStall - 1;
                i_m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                snk_hold = $urandom_range(1, 18) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_drained();
        while (in_bytes_q.size() != 0 || i_s_tvalid || out_beats_q.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // one write per edge; caller lowers the enable
    task automatic wr_cfg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_TAG_CONTROL:   regs_m.tag_control_word    = val;
            CFG_USE_FRAME_TAG: regs_m.use_frame_tag       = val[0];
            CFG_NATIVE_EN:     regs_m.native_match_enable = val[0];
            CFG_NATIVE_VID:    regs_m.native_vlan_id      = val[VidW-1:0];
            CFG_TAG_PROTOCOL:  regs_m.tag_protocol_id     = val;
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_bytes(int n, bit ends, logic [15:0] tag0, bit pat);
        t_frame_byte fb;
        for (int k = 0; k < n; k++) begin
            fb.data = pat ? (k[0] ? 8'hFF : 8'h00) : 8'($urandom);
            fb.last = ends && (k == n - 1);
            fb.tag  = (k == 0) ? tag0 : 16'($urandom);
            in_bytes_q = {in_bytes_q, fb};
        end
    endtask

    function automatic logic [15:0] pick16(logic [15:0] alt);
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return alt;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic rand_config();
        logic [15:0] ctl;
        logic [15:0] vid;
        ctl = pick16(16'($urandom));
        case ($urandom_range(0, 3))
            0: vid = 16'h0000;
            1: vid = 16'h0FFF;
            2: vid = ctl;
            default: vid = 16'($urandom);
        endcase
        // upper bits of the narrow registers carry noise
        vid[15:VidW] = 4'($urandom);
        wr_cfg(CFG_TAG_CONTROL, ctl);
        wr_cfg(CFG_USE_FRAME_TAG, 16'($urandom));
        wr_cfg(CFG_NATIVE_EN, ($urandom_range(0, 3) == 0) ? 16'hFFFE : 16'($urandom));
        wr_cfg(CFG_NATIVE_VID, vid);
        wr_cfg(CFG_TAG_PROTOCOL, pick16(Ethertype8021q));
        if ($urandom_range(0, 1) == 0)
            wr_cfg(CfgAddrW'($urandom_range(int'(CFG_TAG_PROTOCOL) + 1,
                                            (1 << CfgAddrW) - 1)), 16'($urandom));
        cfg_done();
    endtask

    initial begin
        int          nbytes;
        int          flen;
        logic [15:0] tag0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: single-byte frame
        push_bytes(1, 1'b1, 16'hFFFF, 1'b1);
        wait_drained();

        // native match off, all-ones tag: twelve-byte frame ends on last tag byte
        wr_cfg(CFG_NATIVE_EN, 16'h0000);
        wr_cfg(CFG_TAG_CONTROL, 16'hFFFF);
        wr_cfg(CFG_TAG_PROTOCOL, 16'hFFFF);
        for (int k = int'(CFG_TAG_PROTOCOL) + 1; k < (1 << CfgAddrW); k++)
            wr_cfg(CfgAddrW'(k), 16'h0000);
        cfg_done();
        push_bytes(12, 1'b1, 16'h0000, 1'b1);
        wait_drained();

        // settings change in mid-frame: latched control word stays
        wr_cfg(CFG_USE_FRAME_TAG, 16'h0001);
        wr_cfg(CFG_NATIVE_EN, 16'h0001);
        wr_cfg(CFG_NATIVE_VID, 16'h0123);
        wr_cfg(CFG_TAG_CONTROL, 16'h0123);
        cfg_done();
        push_bytes(5, 1'b0, 16'h5ABC, 1'b0);
        wait_drained();
        wr_cfg(CFG_NATIVE_VID, 16'h0ABC);
        wr_cfg(CFG_TAG_CONTROL, 16'h0000);
        wr_cfg(CFG_USE_FRAME_TAG, 16'h0000);
        wr_cfg(CFG_TAG_PROTOCOL, 16'h88A8);
        cfg_done();
        push_bytes(8, 1'b1, 16'($urandom), 1'b0);

        for (int ph = 0; ph < RandPhases; ph++) begin
            wait_drained();
            rand_config();
            if (ph >= RandPhases - 2)
                idle_en = 1'b0;
            if (ph == 1)
                long_hold_req = 1'b1;
            nbytes = 0;
            while (nbytes < PhaseBytes) begin
                case ($urandom_range(0, 9))
                    0, 1: flen = $urandom_range(1, 11);
                    2:    flen = 12;
                    3:    flen = 13;
                    default: flen = $urandom_range(14, 40);
                endcase
                case ($urandom_range(0, 3))
                    0: tag0 = {4'($urandom), regs_m.native_vlan_id};
                    1: tag0 = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                    default: tag0 = 16'($urandom);
                endcase
                push_bytes(flen, 1'b1, tag0, 1'b0);
                nbytes += flen;
            end
        end

        wait_drained();
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vti_pkg.sv
rtl/vti_cfg_regs.sv
rtl/vlan_tag_inserter.sv
tb/vlan_tag_inserter_tb.sv
